### rtl/dsgr_pkg.sv
// ----------------------------------------------------------------------------
// Double-size glyph renderer package
// Shared types and constants for the glyph renderer: the job word passed from
// the front end to the byte sequencer, and the command byte constants.
// ----------------------------------------------------------------------------
package dsgr_pkg;

  // Font geometry and output framing.
  localparam int unsigned GLYPH_COUNT     = 39;
  localparam int unsigned GLYPH_COLS      = 5;
  localparam int unsigned BYTES_PER_GLYPH = 26;
  localparam int unsigned GLYPH_IDX_W     = $clog2(GLYPH_COUNT);

  // Default depth of the job queue between front end and sequencer.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Display controller command bytes.
  localparam logic [7:0] PAGE_CMD   = 8'hB0;
  localparam logic [7:0] COL_HI_CMD = 8'h10;
  localparam logic [7:0] COL_LO_CMD = 8'h00;

  // One classified character, ready for rendering.
  typedef struct packed {
    logic [GLYPH_IDX_W-1:0] glyph_idx;
    logic [6:0]             column;
    logic [2:0]             page_row;
  } dsgr_job_t;

endpackage : dsgr_pkg

### rtl/dsgr_if.sv
// ----------------------------------------------------------------------------
// Glyph renderer channel interfaces
// Valid/ready channels for the character input and the byte output.
// ----------------------------------------------------------------------------
interface dsgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [6:0] column;
  logic [2:0] page_row;

  modport source (output valid, output char_code, output column, output page_row,
                  input ready);
  modport sink   (input valid, input char_code, input column, input page_row,
                  output ready);
endinterface : dsgr_in_if

interface dsgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       is_command;
  logic       last;

  modport source (output valid, output byte_value, output is_command, output last,
                  input ready);
  modport sink   (input valid, input byte_value, input is_command, input last,
                  output ready);
endinterface : dsgr_out_if

### rtl/dsgr_front.sv
// ----------------------------------------------------------------------------
// Glyph renderer front end
// Accepts character words and maps each character code to its font glyph
// index before pushing the job into the queue.
// ----------------------------------------------------------------------------
module dsgr_front
  import dsgr_pkg::*;
(
  dsgr_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       q_push,
  output dsgr_job_t  q_job
);

  // Space, plus and colon come first, then digits, then letters; lower case
  // folds onto upper case and anything else renders blank.
  function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [7:0] code);
    logic [7:0] upper;
    logic [7:0] off;
    upper = code & 8'hDF;
    if (code == 8'h20) begin
      off = 8'd0;
    end else if (code == 8'h2B) begin
      off = 8'd1;
    end else if (code == 8'h3A) begin
      off = 8'd2;
    end else if (code >= 8'h30 && code <= 8'h39) begin
      off = code - 8'h30 + 8'd3;
    end else if ((code >= 8'h41 && code <= 8'h5A) || (code >= 8'h61 && code <= 8'h7A)) begin
      off = upper - 8'h41 + 8'd13;
    end else begin
      off = 8'd0;
    end
    return off[GLYPH_IDX_W-1:0];
  endfunction

  // A word is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_job.glyph_idx = glyph_index(in_ch.char_code);
    q_job.column    = in_ch.column;
    q_job.page_row  = in_ch.page_row;
  end

endmodule : dsgr_front

### rtl/dsgr_queue.sv
// ----------------------------------------------------------------------------
// Glyph renderer job queue
// Small first-in first-out buffer that decouples the front end from the byte
// sequencer. Depth must be at least two.
// ----------------------------------------------------------------------------
module dsgr_queue
  import dsgr_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dsgr_job_t push_job,
  input  logic      pop,
  output dsgr_job_t pop_job,
  output logic      full,
  output logic      empty
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dsgr_job_t       store_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r,  count_nxt;

  assign full    = (count_r == FullCnt);
  assign empty   = (count_r == '0);
  assign pop_job = store_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

endmodule : dsgr_queue

### rtl/dsgr_back.sv
// ----------------------------------------------------------------------------
// Glyph renderer byte sequencer
// Takes one job at a time from the queue and emits its 26 words: cursor
// commands and doubled font columns for the upper page, then for the lower.
// ----------------------------------------------------------------------------
module dsgr_back
  import dsgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  dsgr_job_t  q_job,
  output logic       q_pop,
  dsgr_out_if.source out_ch
);

  // Step codes within one page group of thirteen words.
  localparam logic [3:0] STEP_PAGE   = 4'd0;
  localparam logic [3:0] STEP_COL_LO = 4'd1;
  localparam logic [3:0] STEP_COL_HI = 4'd2;
  localparam logic [3:0] STEP_DATA0  = 4'd3;
  localparam logic [3:0] STEP_LAST   = 4'd12;

  // Font ROM: the five columns of a glyph, first column in the top byte.
  function automatic logic [39:0] glyph_row(input logic [GLYPH_IDX_W-1:0] idx);
    logic [39:0] row;
    unique case (idx)
      6'd0:  row = 40'h00_00_00_00_00;
      6'd1:  row = 40'h08_08_3E_08_08;
      6'd2:  row = 40'h00_36_36_00_00;
      6'd3:  row = 40'h3E_51_49_45_3E;
      6'd4:  row = 40'h00_42_7F_40_00;
      6'd5:  row = 40'h42_61_51_49_46;
      6'd6:  row = 40'h21_41_45_4B_31;
      6'd7:  row = 40'h18_14_12_7F_10;
      6'd8:  row = 40'h27_45_45_45_39;
      6'd9:  row = 40'h3C_4A_49_49_30;
      6'd10: row = 40'h01_71_09_05_03;
      6'd11: row = 40'h36_49_49_49_36;
      6'd12: row = 40'h06_49_49_29_1E;
      6'd13: row = 40'h7E_11_11_11_7E;
      6'd14: row = 40'h7F_49_49_49_36;
      6'd15: row = 40'h3E_41_41_41_22;
      6'd16: row = 40'h7F_41_41_22_1C;
      6'd17: row = 40'h7F_49_49_49_41;
      6'd18: row = 40'h7F_09_09_09_01;
      6'd19: row = 40'h3E_41_49_49_7A;
      6'd20: row = 40'h7F_08_08_08_7F;
      6'd21: row = 40'h00_41_7F_41_00;
      6'd22: row = 40'h20_40_41_3F_01;
      6'd23: row = 40'h7F_08_14_22_41;
      6'd24: row = 40'h7F_40_40_40_40;
      6'd25: row = 40'h7F_02_0C_02_7F;
      6'd26: row = 40'h7F_04_08_10_7F;
      6'd27: row = 40'h3E_41_41_41_3E;
      6'd28: row = 40'h7F_09_09_09_06;
      6'd29: row = 40'h3E_41_51_21_5E;
      6'd30: row = 40'h7F_09_19_29_46;
      6'd31: row = 40'h46_49_49_49_31;
      6'd32: row = 40'h01_01_7F_01_01;
      6'd33: row = 40'h3F_40_40_40_3F;
      6'd34: row = 40'h1F_20_40_20_1F;
      6'd35: row = 40'h3F_40_38_40_3F;
      6'd36: row = 40'h63_14_08_14_63;
      6'd37: row = 40'h07_08_70_08_07;
      6'd38: row = 40'h61_51_49_45_43;
      default: row = '0;
    endcase
    return row;
  endfunction

  // Each nibble bit becomes two adjacent pixel rows.
  function automatic logic [7:0] stretch_nibble(input logic [3:0] nib);
    return {nib[3], nib[3], nib[2], nib[2], nib[1], nib[1], nib[0], nib[0]};
  endfunction

  dsgr_job_t  job_r;
  logic       busy_r,  busy_nxt;
  logic       half_r,  half_nxt;
  logic [3:0] step_r,  step_nxt;
  logic       oval_r;
  logic [7:0] obyte_r, obyte_nxt;
  logic       ocmd_r,  ocmd_nxt;
  logic       olast_r, olast_nxt;

  logic       advance;
  logic       emit;
  logic       finish;
  logic       load;
  logic [3:0] data_step;
  logic [7:0] font_col;
  logic [39:0] row;

  assign out_ch.valid      = oval_r;
  assign out_ch.byte_value = obyte_r;
  assign out_ch.is_command = ocmd_r;
  assign out_ch.last       = olast_r;

  // The output register moves on when it is empty or being taken.
  assign advance = !oval_r || out_ch.ready;
  assign emit    = advance && busy_r;
  assign finish  = emit && half_r && (step_r == STEP_LAST);
  assign load    = (!busy_r || finish) && !q_empty;
  assign q_pop   = load;

  // Sequencer counters.
  always_comb begin
    busy_nxt = busy_r;
    half_nxt = half_r;
    step_nxt = step_r;
    if (load) begin
      busy_nxt = 1'b1;
      half_nxt = 1'b0;
      step_nxt = STEP_PAGE;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      if (step_r == STEP_LAST) begin
        half_nxt = 1'b1;
        step_nxt = STEP_PAGE;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  // Word for the current step.
  always_comb begin
    row       = glyph_row(job_r.glyph_idx);
    data_step = step_r - STEP_DATA0;
    unique case (data_step[3:1])
      3'd0:    font_col = row[39:32];
      3'd1:    font_col = row[31:24];
      3'd2:    font_col = row[23:16];
      3'd3:    font_col = row[15:8];
      default: font_col = row[7:0];
    endcase
    olast_nxt = half_r && (step_r == STEP_LAST);
    unique case (step_r)
      STEP_PAGE: begin
        obyte_nxt = PAGE_CMD + {5'd0, job_r.page_row} + {7'd0, half_r};
        ocmd_nxt  = 1'b1;
      end
      STEP_COL_LO: begin
        obyte_nxt = COL_LO_CMD | {4'd0, job_r.column[3:0]};
        ocmd_nxt  = 1'b1;
      end
      STEP_COL_HI: begin
        obyte_nxt = COL_HI_CMD + {5'd0, job_r.column[6:4]};
        ocmd_nxt  = 1'b1;
      end
      default: begin
        obyte_nxt = stretch_nibble(half_r ? font_col[7:4] : font_col[3:0]);
        ocmd_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      half_r <= 1'b0;
      step_r <= STEP_PAGE;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      half_r <= half_nxt;
      step_r <= step_nxt;
      if (advance) begin
        oval_r <= busy_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
    if (emit) begin
      obyte_r <= obyte_nxt;
      ocmd_r  <= ocmd_nxt;
      olast_r <= olast_nxt;
    end
  end

endmodule : dsgr_back

### rtl/double_size_glyph_renderer_top.sv
// ----------------------------------------------------------------------------
// Double-size glyph renderer
// The first word of a character passes through the job queue, the job register and
// the output register. Throughput: 26 words per character, one per cycle while
// the output is ready; the single byte sequencer and its output register set this.
// Reset (synchronous, rst_n low) empties the job queue and idles the sequencer.
// ----------------------------------------------------------------------------
module double_size_glyph_renderer_top
  import dsgr_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  dsgr_in_if.sink    in_ch,
  dsgr_out_if.source out_ch
);

  dsgr_job_t push_job;
  dsgr_job_t pop_job;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  // Front end: classify the character.
  dsgr_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // Job queue between the two halves.
  dsgr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Byte sequencer.
  dsgr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // The closing word of a character is always a pixel data word.
  a_last_is_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> !out_ch.is_command)
    else $error("last word flagged as command");

  // The sequencer only takes a job that is present.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // Each character opens with a page command right after the previous one closed.
  a_open_with_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last ##1 out_ch.valid |-> out_ch.is_command)
    else $error("character did not open with a command word");

endmodule : double_size_glyph_renderer_top
